### hw/rtl/itrd_pkg.sv
// Shared types, constants and the digit glyph table for the radix digit converter.
package itrd_pkg;

    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd62;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    localparam logic [DIGIT_W-1:0] NUM_DECIMAL = 6'd10;
    localparam logic [DIGIT_W-1:0] NUM_UPPER   = 6'd36;
    localparam logic [DIGIT_W-1:0] NUM_GLYPHS  = 6'd62;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_RD,
        S_LOAD,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new transaction
        logic div_step;   // one restoring division step
        logic store;      // write remainder, prepare next digit
        logic rd_en;      // read the digit store at the emit pointer
        logic out_digit;  // load the output register from the store
        logic out_next;   // step the emit pointer toward the lsd
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic special;    // input radix is bad or value is zero
        logic div_done;   // this step is the last of the division pass
        logic conv_done;  // quotient is zero or the store is full
        logic out_last;   // output register holds the final digit
    } t_dp_sts;

    // Map a digit index to its ASCII glyph: 0-9, A-Z, a-z
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        if (idx < NUM_DECIMAL) begin
            ch = CHAR_ZERO + CHAR_W'(idx);
        end else if (idx < NUM_UPPER) begin
            ch = CHAR_UPPER + CHAR_W'(idx - NUM_DECIMAL);
        end else if (idx < NUM_GLYPHS) begin
            ch = CHAR_LOWER + CHAR_W'(idx - NUM_UPPER);
        end else begin
            ch = CHAR_NONE;
        end
        return ch;
    endfunction

endpackage

### hw/rtl/itrd_if.sv
// Valid/ready channel interfaces for conversion requests and digit results.
interface itrd_in_if;
    import itrd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   value;
    logic [RADIX_W-1:0]   radix;

    modport source (output valid, value, radix, input ready);
    modport sink   (input valid, value, radix, output ready);
endinterface

interface itrd_out_if;
    import itrd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    digit_char;
    logic                 last;
    logic                 bad_radix;

    modport source (output valid, digit_char, last, bad_radix, input ready);
    modport sink   (input valid, digit_char, last, bad_radix, output ready);
endinterface

### hw/rtl/itrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/itrd_dpath.sv
// Datapath: bit-serial divider, digit store and output register.
module itrd_dpath #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  itrd_pkg::t_dp_cmd          i_cmd,
    output itrd_pkg::t_dp_sts          o_sts,
    input  logic [itrd_pkg::VALUE_W-1:0] i_value,
    input  logic [itrd_pkg::RADIX_W-1:0] i_radix,
    output logic [itrd_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                       o_last,
    output logic                       o_bad_radix
);
    import itrd_pkg::*;

    localparam int BW = $clog2(VALUE_BITS);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [VALUE_BITS-1:0] r_quot,    n_quot;
    logic [DIGIT_W-1:0]    r_rem,     n_rem;
    logic [RADIX_W-1:0]    r_radix,   n_radix;
    logic [BW-1:0]         r_bit_cnt, n_bit_cnt;
    logic [AW-1:0]         r_count,   n_count;
    logic [AW-1:0]         r_emit,    n_emit;
    logic [CHAR_W-1:0]     r_char,    n_char;
    logic                  r_last,    n_last;
    logic                  r_bad,     n_bad;

    logic [VALUE_BITS-1:0] in_value;
    logic                  in_bad;
    logic                  in_zero;
    logic [DIGIT_W:0]      rem_shift;
    logic                  rem_ge;
    logic [DIGIT_W-1:0]    rd_digit;

    assign in_value = i_value[VALUE_BITS-1:0];
    assign in_bad   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign in_zero  = (in_value == '0);

    // Restoring division step: shift in the next quotient bit, try subtract
    assign rem_shift = {r_rem, r_quot[VALUE_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, r_radix};

    always_comb begin
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_radix   = r_radix;
        n_bit_cnt = r_bit_cnt;
        n_count   = r_count;
        n_emit    = r_emit;
        n_char    = r_char;
        n_last    = r_last;
        n_bad     = r_bad;
        if (i_cmd.load) begin
            n_quot    = in_value;
            n_rem     = '0;
            n_radix   = i_radix;
            n_bit_cnt = '0;
            n_count   = '0;
            // special results go straight out; ignored otherwise
            n_char    = in_bad ? CHAR_NONE : CHAR_ZERO;
            n_last    = 1'b1;
            n_bad     = in_bad;
        end
        if (i_cmd.div_step) begin
            n_quot    = {r_quot[VALUE_BITS-2:0], rem_ge};
            n_rem     = rem_ge ? DIGIT_W'(rem_shift - {1'b0, r_radix})
                               : DIGIT_W'(rem_shift);
            n_bit_cnt = r_bit_cnt + 1'b1;
        end
        if (i_cmd.store) begin
            n_rem     = '0;
            n_bit_cnt = '0;
            n_emit    = r_count;
            n_count   = r_count + 1'b1;
        end
        if (i_cmd.out_digit) begin
            n_char = glyph(rd_digit);
            n_last = (r_emit == '0);
            n_bad  = 1'b0;
        end
        if (i_cmd.out_next) begin
            n_emit = r_emit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_radix   <= n_radix;
        r_bit_cnt <= n_bit_cnt;
        r_count   <= n_count;
        r_emit    <= n_emit;
        r_char    <= n_char;
        r_last    <= n_last;
        r_bad     <= n_bad;
    end

    itrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.store),
        .i_wr_addr (r_count),
        .i_wr_data (r_rem),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_emit),
        .o_rd_data (rd_digit)
    );

    assign o_sts.special   = in_bad || in_zero;
    assign o_sts.div_done  = (r_bit_cnt == BW'(VALUE_BITS - 1));
    assign o_sts.conv_done = (r_quot == '0) || (r_count == AW'(MAX_DIGITS - 1));
    assign o_sts.out_last  = r_last;

    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_bad_radix  = r_bad;

    // Partial remainder stays below the radix during a division pass
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_radix))
        else $error("remainder reached the radix");

    // Emit pointer never steps below address zero, the least significant digit
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_next |-> (r_emit != '0))
        else $error("emit pointer underflow");

    // Each stored digit restarts the divider
    a_store_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |=> (r_rem == '0) && (r_bit_cnt == '0))
        else $error("divider not restarted after store");
endmodule

### hw/rtl/itrd_ctrl.sv
// Controller: state machine sequencing division passes and digit emission.
module itrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  itrd_pkg::t_dp_sts i_sts,
    output itrd_pkg::t_dp_cmd o_cmd
);
    import itrd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.special ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.conv_done ? S_RD : S_DIV;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.out_digit = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A special request produces its single result right away
    a_special_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_sts.special) |=> (r_state == S_OUT))
        else $error("special request did not go straight to output");

    // Final digit taken returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_sts.out_last) |=> o_in_ready)
        else $error("block not idle after final digit");

    // Busy after an accepted request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> !o_in_ready)
        else $error("second request accepted during a conversion");
endmodule

### hw/rtl/integer_to_radix_digits.sv
// Top level: converts an unsigned integer to ASCII digits in radix 2 to 62.
// Operation: each digit takes one division pass in the shared bit-serial divider
//   (one quotient bit a cycle, then one store write); the store read and output load
//   (S_RD, S_LOAD) follow the last pass before the first digit shows.
// Throughput: one transaction at a time; each digit is then read from the store and loaded,
//   then held through output stall. Bad radix or zero value: result the cycle after accept.
// Reset: synchronous, active low; clears the controller only, the digit store has no reset.
module integer_to_radix_digits #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_DIGITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itrd_in_if.sink    i_in,
    itrd_out_if.source o_out
);
    import itrd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: accepts one transaction, runs division passes, then
    // walks the digit store from most significant digit down.
    itrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: divider registers, digit store RAM and the output
    // register that holds each result until the sink takes it.
    itrd_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_value      (i_in.value),
        .i_radix      (i_in.radix),
        .o_digit_char (o_out.digit_char),
        .o_last       (o_out.last),
        .o_bad_radix  (o_out.bad_radix)
    );
endmodule

### verif/tb_integer_to_radix_digits.sv
// Self-checking testbench: directed and random conversions scored against a digit predictor.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;
    import itrd_pkg::*;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;

    // Slowest legal run: about 150 transactions, each up to 64 binary digits through the divider,
    // plus 64 emitted digits under a heavy receiver stall, plus one long hold-off; the limit
    // allows a wide margin over that.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 200;    // quiet time after the last digit, for stray results
    localparam int HOLD_CYCLES   = 2500;   // long receiver hold-off that backs up the input
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 40;     // per idling phase
    localparam int DIRECTED_ROWS = 23;

    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_BITS >= VALUE_W) ? ALL_ONES : ((VALUE_W'(1) << VALUE_BITS) - VALUE_W'(1));
    localparam string DIGIT_SET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    localparam logic [RADIX_W-1:0] RADIX_TOP = 6'd63;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_digit_result;

    // One directed transaction; rows with typed set carry their single result inline
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               typed;
        logic [CHAR_W-1:0]  ch;
        logic               bad;
    } t_stim_row;

    t_stim_row stim_table [0:DIRECTED_ROWS-1] = '{
        // zero value gives a lone '0'
        '{64'd0,          6'd10,     1'b1, CHAR_ZERO,  1'b0},
        '{64'd0,          RADIX_MIN, 1'b1, CHAR_ZERO,  1'b0},
        // radix outside the legal range gives one flagged result
        '{64'd123,        6'd0,      1'b1, CHAR_NONE,  1'b1},
        '{64'd123,        6'd1,      1'b1, CHAR_NONE,  1'b1},
        '{64'd123,        RADIX_TOP, 1'b1, CHAR_NONE,  1'b1},
        '{64'd0,          RADIX_TOP, 1'b1, CHAR_NONE,  1'b1},
        '{ALL_ONES,       6'd0,      1'b1, CHAR_NONE,  1'b1},
        // single-digit values at the edges of each glyph group
        '{64'd1,          RADIX_MIN, 1'b1, 7'h31,      1'b0},   // '1'
        '{64'd9,          6'd10,     1'b1, 7'h39,      1'b0},   // '9'
        '{64'd10,         RADIX_MAX, 1'b1, CHAR_UPPER, 1'b0},   // 'A'
        '{64'd35,         6'd36,     1'b1, 7'h5A,      1'b0},   // 'Z'
        '{64'd36,         RADIX_MAX, 1'b1, CHAR_LOWER, 1'b0},   // 'a'
        '{64'd61,         RADIX_MAX, 1'b1, 7'h7A,      1'b0},   // 'z'
        // multi-digit rows, scored by the predictor
        '{ALL_ONES,       RADIX_MIN, 1'b0, CHAR_NONE,  1'b0},
        '{64'h8000_0000_0000_0000, RADIX_MIN, 1'b0, CHAR_NONE, 1'b0},
        '{ALL_ONES,       6'd3,      1'b0, CHAR_NONE,  1'b0},
        '{ALL_ONES,       6'd10,     1'b0, CHAR_NONE,  1'b0},
        '{ALL_ONES,       6'd16,     1'b0, CHAR_NONE,  1'b0},
        '{ALL_ONES,       RADIX_MAX, 1'b0, CHAR_NONE,  1'b0},
        '{64'd62,         RADIX_MAX, 1'b0, CHAR_NONE,  1'b0},
        '{64'd255,        6'd16,     1'b0, CHAR_NONE,  1'b0},
        '{64'd1234567890, 6'd10,     1'b0, CHAR_NONE,  1'b0},
        '{64'h0123_4567_89AB_CDEF, 6'd36, 1'b0, CHAR_NONE, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    itrd_in_if  in_ch ();
    itrd_out_if out_ch ();

    integer_to_radix_digits #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predictor state, mirrors what the block keeps between transactions
    logic [VALUE_W-1:0] model_quotient = '0;
    logic [6:0]         model_count    = '0;

    t_digit_result pending_digits [$];   // digits still owed by the block, oldest first
    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int cycle_count   = 0;

    // Work out the digit results of one conversion, most significant first
    function automatic void predict_digits(input logic [VALUE_W-1:0] num,
                                           input logic [RADIX_W-1:0] base,
                                           ref t_digit_result digits [$]);
        logic [DIGIT_W-1:0] rems [MAX_DIGITS];
        logic [VALUE_W-1:0] divisor;
        int n;
        digits.delete();
        n = 0;
        num = num & VALUE_MASK;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            model_quotient = '0;
            model_count    = '0;
            digits.push_back('{CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        if (num == '0) begin
            model_quotient = '0;
            model_count    = '0;
            digits.push_back('{CHAR_W'(DIGIT_SET[0]), 1'b1, 1'b0});
            return;
        end
        // Peel off remainders, least significant first; stop when the store is full
        divisor = VALUE_W'(base);
        model_quotient = num;
        while (model_quotient != '0 && n < MAX_DIGITS) begin
            rems[n] = DIGIT_W'(model_quotient % divisor);
            model_quotient = model_quotient / divisor;
            n++;
        end
        model_count = 7'(n);
        for (int k = n - 1; k >= 0; k--) begin
            digits.push_back('{CHAR_W'(DIGIT_SET[rems[k]]), (k == 0), 1'b0});
        end
    endfunction

    // Offer one transaction after a random gap, then queue what it must produce
    task automatic send_conversion(input logic [VALUE_W-1:0] num,
                                   input logic [RADIX_W-1:0] base,
                                   input logic               typed,
                                   input t_digit_result      golden);
        t_digit_result digits [$];
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= num;
        in_ch.radix <= base;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predict_digits(num, base, digits);
        if (typed) begin
            pending_digits.push_back(golden);
        end else begin
            foreach (digits[j]) begin
                pending_digits.push_back(digits[j]);
            end
        end
    endtask

    // Hold the sender until every owed digit has been taken
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (pending_digits.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off counted here on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Score every digit taken off the output channel against the oldest owed one
    initial begin
        t_digit_result got;
        t_digit_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got = '{out_ch.digit_char, out_ch.last, out_ch.bad_radix};
                if (pending_digits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("cycle %0d: unexpected digit char=%h last=%b bad_radix=%b",
                                 cycle_count, got.ch, got.last, got.bad);
                    end
                end else begin
                    want = pending_digits.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("cycle %0d: expected char=%h last=%b bad_radix=%b",
                                     cycle_count, want.ch, want.last, want.bad);
                            $display("    got char=%h last=%b bad_radix=%b",
                                     got.ch, got.last, got.bad);
                        end
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed table, a receiver hold-off burst, then three idling phases of random traffic
    initial begin
        logic [VALUE_W-1:0] num;
        logic [VALUE_W-1:0] raw;
        logic [RADIX_W-1:0] base;
        int sel;
        int len;

        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.radix <= '0;
        send_idle_pct = 12;
        recv_idle_pct = 78;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (stim_table[r]) begin
            send_conversion(stim_table[r].value, stim_table[r].radix, stim_table[r].typed,
                            '{stim_table[r].ch, 1'b1, stim_table[r].bad});
        end

        // Stall the receiver for a long stretch and keep offering, so the input backs up
        hold_requests++;
        for (int h = 0; h < 6; h++) begin
            send_conversion(VALUE_W'($urandom_range(1, 100000)), 6'd10, 1'b0, '0);
        end

        for (int phase = 0; phase < 3; phase++) begin
            // Pause until everything owed has come out, then change the idling mix
            wait_for_drain();
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Keep most values short so runs stay fast; some span the full width
                raw = {$urandom, $urandom};
                sel = $urandom_range(99);
                if (sel < 5) begin
                    num = '0;
                end else begin
                    if (sel < 65) begin
                        len = $urandom_range(1, 16);
                    end else if (sel < 88) begin
                        len = $urandom_range(17, 48);
                    end else begin
                        len = VALUE_W;
                    end
                    num = (len == VALUE_W) ? raw
                                           : (raw & ((VALUE_W'(1) << len) - VALUE_W'(1)));
                end
                // Lean on the end radices and the illegal ones
                sel = $urandom_range(99);
                if (sel < 4) begin
                    base = 6'd0;
                end else if (sel < 8) begin
                    base = 6'd1;
                end else if (sel < 12) begin
                    base = RADIX_TOP;
                end else if (sel < 22) begin
                    base = RADIX_MIN;
                end else if (sel < 32) begin
                    base = RADIX_MAX;
                end else begin
                    base = RADIX_W'($urandom_range(2, 62));
                end
                send_conversion(num, base, 1'b0, '0);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_digits.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
